// ===== rtl/frame_peak_limiter_defines.svh =====
// Assertion macros for the frame peak limiter checker.
// No dependencies; included by fpl_checker.sv.
`ifndef FRAME_PEAK_LIMITER_DEFINES_SVH
`define FRAME_PEAK_LIMITER_DEFINES_SVH

// same-cycle implication, off during reset
`define FPL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpl_checker: property violated");

// next-cycle implication, off during reset
`define FPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpl_checker: property violated");

`endif

// ===== rtl/fpl_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// frame peak limiter. No dependencies.
package fpl_pkg;

  localparam int FRAME_LEN    = 80;
  localparam int SAMPLE_WIDTH = 24;

  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int PEAK_W    = SAMPLE_WIDTH - 1;
  localparam int PROD_W    = 2 * SAMPLE_WIDTH;
  localparam int SQ_W      = 2 * PEAK_W;
  localparam int LIMIT_W   = 15;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int OUT_W     = 16;
  localparam int MAG_W     = OUT_W - 1;
  localparam int DIV_CNT_W = $clog2(GAIN_FRAC);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30000);
  localparam logic [GAIN_W-1:0]  UNITY_GAIN  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [MAG_W-1:0]   OUT_MAX     = '1;

  typedef struct packed {
    logic take;
    logic scale_mul;
    logic out_load;
    logic lim_mul;
    logic peak_mul;
    logic div_init;
    logic div_step;
    logic gain_load;
  } fpl_cmd_t;

  typedef struct packed {
    logic frame_last;
    logic over_limit;
  } fpl_sts_t;

endpackage

// ===== rtl/frame_peak_limiter.sv =====
// Frame peak limiter top level: controller plus datapath.
// Depends on fpl_pkg, fpl_ctrl and fpl_dp.
//
// Usage:
//   Input channel in_valid/in_stall carries one signed sample_in per transfer.
//   Output channel out_valid/out_stall returns exactly one result per input:
//   the sample of the previous frame at the same index, scaled by that
//   frame's gain and clamped to +/-32767, with frame_first and gain_reduced.
//   cfg_we/cfg_wdata write limit_level; write it only while the block is idle.
// Sequence:
//   An input passes the frame memory read register and the multiplier product
//   register, then loads into the output register once it is free. The
//   sequencer holds one item at a time. After the last sample of a frame the
//   gain is fixed: a gain load alone when the peak is within the limit, else
//   two squarings on the shared multiplier and a 16-step restoring divider.
// Reset (rst, synchronous): index and peak clear, gain is unity, limit is
//   30000, the first frame reads as zeros.
// Stall: a waiting result holds in the output register; the next input is
//   still taken and its result waits until the output register frees.
module frame_peak_limiter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [fpl_pkg::LIMIT_W-1:0]             cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [fpl_pkg::SAMPLE_WIDTH-1:0] sample_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [fpl_pkg::OUT_W-1:0]        sample_out,
  output logic                                    frame_first,
  output logic                                    gain_reduced
);

  fpl_pkg::fpl_cmd_t cmd;
  fpl_pkg::fpl_sts_t sts;

  fpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_in    (sample_in),
    .cmd          (cmd),
    .sts          (sts),
    .sample_out   (sample_out),
    .frame_first  (frame_first),
    .gain_reduced (gain_reduced)
  );

endmodule

// ===== rtl/fpl_ctrl.sv =====
// Sequencer for the frame peak limiter: handshakes, per-sample steps and
// the frame-end gain computation. Depends on fpl_pkg.
module fpl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fpl_pkg::fpl_sts_t sts,
  output fpl_pkg::fpl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROD,
    S_LIMSQ,
    S_PKSQ,
    S_DIVI,
    S_DIV,
    S_GAIN
  } state_t;

  state_t                          state;
  logic [fpl_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic                            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.take      = (state == S_IDLE) && in_valid;
    cmd.scale_mul = (state == S_READ);
    cmd.out_load  = (state == S_PROD) && out_free;
    cmd.lim_mul   = (state == S_LIMSQ);
    cmd.peak_mul  = (state == S_PKSQ);
    cmd.div_init  = (state == S_DIVI);
    cmd.div_step  = (state == S_DIV);
    cmd.gain_load = (state == S_GAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_PROD;
        S_PROD: begin
          if (out_free) begin
            if (!sts.frame_last) begin
              state <= S_IDLE;
            end else if (sts.over_limit) begin
              state <= S_LIMSQ;
            end else begin
              state <= S_GAIN;
            end
          end
        end
        S_LIMSQ: state <= S_PKSQ;
        S_PKSQ:  state <= S_DIVI;
        S_DIVI: begin
          div_cnt <= fpl_pkg::DIV_CNT_W'(fpl_pkg::GAIN_FRAC - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_GAIN;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_GAIN:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fpl_dp.sv =====
// Datapath of the frame peak limiter: frame memory, peak tracking, shared
// multiplier, restoring divider, gain and output registers. Depends on fpl_pkg.
module fpl_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [fpl_pkg::LIMIT_W-1:0]             cfg_wdata,
  input  logic signed [fpl_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  fpl_pkg::fpl_cmd_t                       cmd,
  output fpl_pkg::fpl_sts_t                       sts,
  output logic signed [fpl_pkg::OUT_W-1:0]        sample_out,
  output logic                                    frame_first,
  output logic                                    gain_reduced
);

  localparam int SW = fpl_pkg::SAMPLE_WIDTH;

  logic [SW-1:0]                        mem [fpl_pkg::FRAME_LEN];
  logic [SW-1:0]                        rd_data;
  logic [fpl_pkg::IDX_W-1:0]            idx;
  logic                                 primed;
  logic                                 rd_primed;
  logic [fpl_pkg::LIMIT_W-1:0]          limit_level;
  logic [fpl_pkg::PEAK_W-1:0]           running_peak;
  logic [fpl_pkg::PEAK_W-1:0]           frame_peak;
  logic [fpl_pkg::PEAK_W-1:0]           peak_cand;
  logic                                 first_q;
  logic                                 last_q;
  logic [fpl_pkg::GAIN_W-1:0]           gain;
  logic                                 gain_red;

  logic                                 rd_neg;
  logic [SW-1:0]                        rd_val;
  logic [SW-1:0]                        rd_mag;
  logic                                 sc_neg;
  logic [SW-1:0]                        mul_a;
  logic [SW-1:0]                        mul_b;
  logic [fpl_pkg::PROD_W-1:0]           mul_p;

  logic [fpl_pkg::PROD_W-fpl_pkg::GAIN_FRAC-1:0] scaled;
  logic [fpl_pkg::MAG_W-1:0]            mag;
  logic [fpl_pkg::OUT_W-1:0]            mag_ext;

  logic [2*fpl_pkg::LIMIT_W-1:0]        lim_sq;
  logic [fpl_pkg::SQ_W-1:0]             rem;
  logic [fpl_pkg::SQ_W:0]               rem_sh;
  logic [fpl_pkg::SQ_W:0]               divisor;
  logic                                 div_ge;
  logic [fpl_pkg::GAIN_FRAC-1:0]        quot;

  // frame memory, read-before-write at the same index
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[idx] <= sample_in;
      rd_data  <= mem[idx];
    end
  end

  assign peak_cand = (!sample_in[SW-1] && (sample_in[SW-2:0] > running_peak))
                     ? sample_in[SW-2:0] : running_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      primed       <= 1'b0;
      limit_level  <= fpl_pkg::LIMIT_RESET;
      running_peak <= '0;
      gain         <= fpl_pkg::UNITY_GAIN;
      gain_red     <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_level <= cfg_wdata;
      end
      if (cmd.take) begin
        if (idx == fpl_pkg::IDX_W'(fpl_pkg::FRAME_LEN - 1)) begin
          idx          <= '0;
          primed       <= 1'b1;
          running_peak <= '0;
        end else begin
          idx          <= idx + 1'b1;
          running_peak <= peak_cand;
        end
      end
      if (cmd.gain_load) begin
        gain     <= sts.over_limit ? {1'b0, quot} : fpl_pkg::UNITY_GAIN;
        gain_red <= sts.over_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      first_q    <= (idx == '0);
      last_q     <= (idx == fpl_pkg::IDX_W'(fpl_pkg::FRAME_LEN - 1));
      frame_peak <= peak_cand;
      rd_primed  <= primed;
    end
  end

  assign sts.frame_last = last_q;
  assign sts.over_limit = frame_peak > fpl_pkg::PEAK_W'(limit_level);

  // reads during the first frame, before any frame is stored, return zero
  assign rd_val = rd_primed ? rd_data : '0;
  assign rd_neg = rd_val[SW-1];
  assign rd_mag = rd_neg ? (~rd_val + 1'b1) : rd_val;

  always_comb begin
    priority if (cmd.scale_mul) begin
      mul_a = rd_mag;
      mul_b = SW'(gain);
    end else if (cmd.lim_mul) begin
      mul_a = SW'(limit_level);
      mul_b = SW'(limit_level);
    end else begin
      mul_a = SW'(frame_peak);
      mul_b = SW'(frame_peak);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale_mul || cmd.lim_mul || cmd.peak_mul) begin
      mul_p <= fpl_pkg::PROD_W'(mul_a) * fpl_pkg::PROD_W'(mul_b);
    end
    if (cmd.scale_mul) begin
      sc_neg <= rd_neg;
    end
    if (cmd.peak_mul) begin
      lim_sq <= mul_p[2*fpl_pkg::LIMIT_W-1:0];
    end
  end

  // truncate toward zero on the magnitude, clamp, restore sign
  assign scaled  = mul_p[fpl_pkg::PROD_W-1:fpl_pkg::GAIN_FRAC];
  assign mag     = (scaled > $bits(scaled)'(fpl_pkg::OUT_MAX))
                   ? fpl_pkg::OUT_MAX : scaled[fpl_pkg::MAG_W-1:0];
  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out   <= sc_neg ? -mag_ext : mag_ext;
      frame_first  <= first_q;
      gain_reduced <= gain_red;
    end
  end

  // restoring division: lim^2 << 16 / peak^2, one quotient bit per step
  assign divisor = {1'b0, mul_p[fpl_pkg::SQ_W-1:0]};
  assign rem_sh  = {rem, 1'b0};
  assign div_ge  = rem_sh >= divisor;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= fpl_pkg::SQ_W'(lim_sq);
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= div_ge ? fpl_pkg::SQ_W'(rem_sh - divisor) : fpl_pkg::SQ_W'(rem_sh);
      quot <= {quot[fpl_pkg::GAIN_FRAC-2:0], div_ge};
    end
  end

endmodule

// ===== rtl/fpl_checker.sv =====
// Port-level checker for the frame peak limiter, bound to the top level.
// Depends on fpl_pkg and frame_peak_limiter_defines.svh.
`include "frame_peak_limiter_defines.svh"

module fpl_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [fpl_pkg::OUT_W-1:0]        sample_out,
  input logic                                    frame_first,
  input logic                                    gain_reduced
);

  // one item in the sequencer at a time
  `FPL_ASSERT_NEXT(a_no_back_to_back, in_valid && !in_stall, in_stall)

  // clamp is symmetric, most negative code never leaves
  `FPL_ASSERT_IMPL(a_no_min_code, out_valid, sample_out != 16'sh8000)

  // output register is empty out of reset
  `FPL_ASSERT_IMPL(a_empty_after_reset, $past(rst), !out_valid)

  // a stalled result holds
  `FPL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(sample_out) && $stable(frame_first) && $stable(gain_reduced))

endmodule

bind frame_peak_limiter fpl_checker u_fpl_checker (.*);
